@@ rtl/lse_pkg.sv @@
`timescale 1ns / 1ps
// lse_pkg.sv: types, codes and fixed constants of the Legendre series evaluator.
// No dependencies; imported by legendre_series_evaluation and lse_checker.
package lse_pkg;

  typedef logic              cmd_t;
  typedef logic [15:0]       point_t;
  typedef logic signed [31:0] coeff_t;
  typedef logic [1:0]        cfg_idx_t;
  typedef logic [31:0]       cfg_data_t;

  // command codes
  localparam cmd_t CMD_LOAD = 1'b0;
  localparam cmd_t CMD_EVAL = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t CFG_NUM_COEFFS = 2'd0;
  localparam cfg_idx_t CFG_X_STEP     = 2'd1;
  localparam cfg_idx_t CFG_INV_BETA   = 2'd2;

  // configuration reset values
  localparam logic [6:0]  NUM_COEFFS_RST = 7'd16;
  localparam logic [30:0] X_STEP_RST     = 31'd2147483;
  localparam logic [31:0] INV_BETA_RST   = 32'd1677722;

  // 1.0 in Q2.30
  localparam coeff_t ONE_Q30 = 32'sh4000_0000;

  // shared multiplier: 33 x 32 unsigned, 65-bit product
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 32;
  localparam int PROD_W = 65;

  typedef enum logic [4:0] {
    ST_IDLE,  // waiting for a transaction
    ST_XC,    // clamp x, set up the walk
    ST_CPG,   // issue |g_l| * |P_l|
    ST_CPF,   // round g product, issue |f_l| * |P_l|
    ST_GLO,   // round f product, issue g low partial
    ST_GHI,   // issue g high partial
    ST_FLO,   // accumulate g term, issue f low partial
    ST_FHI,   // issue f high partial
    ST_FACC,  // accumulate f term, advance order
    ST_T1,    // round x*P_{l-1}, issue (l-1)*P_{l-2}
    ST_T2,    // issue (2l-1)*xp
    ST_T3,    // form the numerator
    ST_NABS,  // numerator magnitude
    ST_RLO,   // issue numerator low * recip
    ST_RHI,   // issue numerator high * recip
    ST_RP,    // round and saturate P_l
    ST_FIN    // saturate sums, raise strobe
  } state_t;

endpackage

@@ rtl/legendre_series_evaluation.sv @@
`timescale 1ns / 1ps
// legendre_series_evaluation.sv: top level of the Legendre series evaluator.
// Depends on lse_pkg (types, codes, state encoding).
//
//  channel  ports                                      handshake
//  -------  -----------------------------------------  ------------------------------
//  input    in_cmd in_index in_g_coeff in_f_coeff      taken when start && !busy
//  result   out_point_echo out_g_value out_f_value     one cycle, marked by out_valid
//  config   cfg_index cfg_data                         written when cfg_we is high
//
// Busy never rises for a load. An evaluate transaction keeps busy high while it
// walks orders 0 to n-1, n = min(num_coeffs, MAX_COEFFS). Every multiply step goes
// through the single 33x32 multiplier, one product per cycle: g and f products and
// their weighted low and high partials for the series terms; from order two upward
// also x*P_{l-1}, (l-1)*P_{l-2}, (2l-1)*xp and the quotient partials.
// The result strobe comes in the same cycle that busy falls; a new start is taken then.
// rst_n (synchronous) idles the sequencer and restores the configuration defaults; the
// coefficient stores are not cleared. The receiver cannot stall the result.
module legendre_series_evaluation #(
  parameter int MAX_COEFFS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transaction
  input  logic               start,
  output logic               busy,
  input  lse_pkg::cmd_t      in_cmd,
  input  lse_pkg::point_t    in_index,
  input  lse_pkg::coeff_t    in_g_coeff,
  input  lse_pkg::coeff_t    in_f_coeff,
  // configuration writes
  input  logic               cfg_we,
  input  lse_pkg::cfg_idx_t  cfg_index,
  input  lse_pkg::cfg_data_t cfg_data,
  // result transaction
  output logic               out_valid,
  output lse_pkg::point_t    out_point_echo,
  output lse_pkg::coeff_t    out_g_value,
  output lse_pkg::coeff_t    out_f_value
);

  import lse_pkg::*;

  // order index and order count widths
  localparam int LW  = $clog2(MAX_COEFFS);
  localparam int NW  = ($clog2(MAX_COEFFS + 1) > 7) ? $clog2(MAX_COEFFS + 1) : 7;
  // 2l+1 and the running weight (2l+1)*inv_beta
  localparam int KW  = $clog2(2 * MAX_COEFFS);
  localparam int WW  = 32 + KW;
  // |(2l-1)*xp - (l-1)*P_{l-2}| and its part above the low 32 bits
  localparam int NMW = 31 + $clog2(3 * MAX_COEFFS);
  localparam int NHW = NMW - 32;
  // one series term and the accumulator
  localparam int TW  = 42 + KW;
  localparam int AW  = TW + 1 + LW;
  // rounded recurrence quotient before saturation
  localparam int RW  = NHW + 33;

  // ---------------------------------------------------------------------------
  // Reciprocal table: round(2^32 / l), unused below l = 2
  // ---------------------------------------------------------------------------
  logic [31:0] recip_tab [MAX_COEFFS];

  for (genvar gi = 0; gi < MAX_COEFFS; gi++) begin : g_rcp
    localparam longint unsigned Den = (gi < 2) ? 1 : gi;
    localparam longint unsigned Rcp = (gi < 2) ? 0 : (((64'd1 << 32) + Den / 2) / Den);
    assign recip_tab[gi] = 32'(Rcp);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [LW-1:0]           l_r, l_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [6:0]              num_coeffs_r;
  logic [30:0]             x_step_r;
  logic [31:0]             inv_beta_r;

  point_t                  idx_r, idx_nxt;
  coeff_t                  x_r, x_nxt;
  coeff_t                  p_r, p_nxt;
  coeff_t                  p1_r, p1_nxt;
  coeff_t                  p2_r, p2_nxt;
  logic [WW-1:0]           w_r, w_nxt;
  logic signed [AW-1:0]    acc_g_r, acc_g_nxt;
  logic signed [AW-1:0]    acc_f_r, acc_f_nxt;
  logic [32:0]             cpg_mag_r, cpg_mag_nxt;
  logic                    cpg_neg_r, cpg_neg_nxt;
  logic [32:0]             cpf_mag_r, cpf_mag_nxt;
  logic                    cpf_neg_r, cpf_neg_nxt;
  logic [PROD_W-1:0]       lo_r, lo_nxt;
  logic [31:0]             xp_mag_r, xp_mag_nxt;
  logic                    xp_neg_r, xp_neg_nxt;
  logic signed [NMW:0]     t2_r, t2_nxt;
  logic signed [NMW:0]     num_r, num_nxt;
  logic [NMW-1:0]          num_mag_r, num_mag_nxt;
  logic                    num_neg_r, num_neg_nxt;
  logic [31:0]             recip_r, recip_nxt;
  point_t                  out_point_r, out_point_nxt;
  coeff_t                  out_g_r, out_g_nxt;
  coeff_t                  out_f_r, out_f_nxt;

  // shared multiplier
  logic [MUL_AW-1:0]       mul_a;
  logic [MUL_BW-1:0]       mul_b;
  logic                    mul_neg;
  logic [PROD_W-1:0]       prod_r;
  logic                    prod_neg_r;

  // coefficient stores
  coeff_t                  g_mem [MAX_COEFFS];
  coeff_t                  f_mem [MAX_COEFFS];
  coeff_t                  g_rd_r, f_rd_r;
  logic                    mem_we;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mag32(input coeff_t v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic coeff_t sat_acc(input logic signed [AW-1:0] a);
    if (a[AW-1:31] == '0 || a[AW-1:31] == '1) begin
      sat_acc = a[31:0];
    end else if (a[AW-1]) begin
      sat_acc = 32'sh8000_0000;
    end else begin
      sat_acc = 32'sh7fff_ffff;
    end
  endfunction

  logic [NW-1:0]           n_cnt;
  logic                    n_zero;
  logic [LW-1:0]           l_last;
  logic [PROD_W-1:0]       rnd_sum;      // product + half LSB at bit 30
  logic [PROD_W-1:0]       acc_lo_sum;   // low partial + half LSB at bit 24
  logic [PROD_W-1:0]       rec_lo_sum;   // low partial + half LSB at bit 32
  logic [TW-1:0]           term;
  logic signed [AW-1:0]    term_ext;
  logic signed [NMW:0]     prod_sg;
  logic [NMW-1:0]          num_abs;
  logic [RW-1:0]           r_mag;
  coeff_t                  p_sat;
  coeff_t                  x_new;

  // too many orders clamps to the store depth
  assign n_cnt  = (NW'(num_coeffs_r) > NW'(MAX_COEFFS)) ? NW'(MAX_COEFFS)
                                                         : NW'(num_coeffs_r);
  assign n_zero = (n_cnt == '0);
  assign l_last = LW'(n_cnt - NW'(1));

  assign rnd_sum    = prod_r + (PROD_W'(1) << 29);
  assign acc_lo_sum = lo_r + (PROD_W'(1) << 23);
  assign rec_lo_sum = lo_r + (PROD_W'(1) << 31);

  // term = (hi * 2^8) + round(lo / 2^24), exact split of the 24-bit shift
  assign term     = (TW'(prod_r[32+KW:0]) << 8) + TW'(acc_lo_sum[PROD_W-1:24]);
  assign term_ext = $signed({{(AW-TW){1'b0}}, term});

  assign prod_sg  = prod_neg_r ? -$signed({1'b0, prod_r[NMW-1:0]})
                               :  $signed({1'b0, prod_r[NMW-1:0]});
  assign num_abs  = num_r[NMW] ? NMW'(-num_r) : NMW'(num_r);

  // P_l magnitude, rounded after the 32-bit shift, then Q2.30 saturation
  assign r_mag = RW'(prod_r[NHW+31:0]) + RW'(rec_lo_sum[PROD_W-1:32]);

  always_comb begin
    if (num_neg_r) begin
      p_sat = (|r_mag[RW-1:31]) ? 32'sh8000_0000 : 32'(32'd0 - r_mag[31:0]);
    end else begin
      p_sat = (|r_mag[RW-1:31]) ? 32'sh7fff_ffff : r_mag[31:0];
    end
  end

  // x = t*x_step - 1, only the upper clamp can bite
  assign x_new = (|prod_r[PROD_W-1:31]) ? ONE_Q30 : (coeff_t'(prod_r[31:0]) - ONE_Q30);

  assign mem_we = start && !busy && (in_cmd == CMD_LOAD) &&
                  (in_index < 16'(MAX_COEFFS));

  // ---------------------------------------------------------------------------
  // Sequencer: next state, datapath updates and multiplier operands
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    l_nxt         = l_r;
    out_valid_nxt = 1'b0;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    w_nxt         = w_r;
    acc_g_nxt     = acc_g_r;
    acc_f_nxt     = acc_f_r;
    cpg_mag_nxt   = cpg_mag_r;
    cpg_neg_nxt   = cpg_neg_r;
    cpf_mag_nxt   = cpf_mag_r;
    cpf_neg_nxt   = cpf_neg_r;
    lo_nxt        = lo_r;
    xp_mag_nxt    = xp_mag_r;
    xp_neg_nxt    = xp_neg_r;
    t2_nxt        = t2_r;
    num_nxt       = num_r;
    num_mag_nxt   = num_mag_r;
    num_neg_nxt   = num_neg_r;
    recip_nxt     = recip_r;
    out_point_nxt = out_point_r;
    out_g_nxt     = out_g_r;
    out_f_nxt     = out_f_r;
    mul_a         = '0;
    mul_b         = '0;
    mul_neg       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start && in_cmd == CMD_EVAL) begin
          idx_nxt   = in_index;
          mul_a     = MUL_AW'(x_step_r);
          mul_b     = MUL_BW'(in_index);
          state_nxt = ST_XC;
        end
      end

      ST_XC: begin
        x_nxt     = x_new;
        acc_g_nxt = '0;
        acc_f_nxt = '0;
        if (n_zero) begin
          state_nxt = ST_FIN;
        end else begin
          l_nxt     = '0;
          p_nxt     = ONE_Q30;
          p1_nxt    = x_new;
          p2_nxt    = ONE_Q30;
          w_nxt     = WW'(inv_beta_r);
          state_nxt = ST_CPG;
        end
      end

      ST_CPG: begin
        mul_a     = {1'b0, mag32(g_rd_r)};
        mul_b     = mag32(p_r);
        mul_neg   = g_rd_r[31] ^ p_r[31];
        state_nxt = ST_CPF;
      end

      ST_CPF: begin
        cpg_mag_nxt = rnd_sum[62:30];
        cpg_neg_nxt = prod_neg_r;
        mul_a       = {1'b0, mag32(f_rd_r)};
        mul_b       = mag32(p_r);
        mul_neg     = f_rd_r[31] ^ p_r[31];
        state_nxt   = ST_GLO;
      end

      ST_GLO: begin
        cpf_mag_nxt = rnd_sum[62:30];
        cpf_neg_nxt = prod_neg_r;
        mul_a       = cpg_mag_r;
        mul_b       = w_r[31:0];
        state_nxt   = ST_GHI;
      end

      ST_GHI: begin
        lo_nxt    = prod_r;
        mul_a     = cpg_mag_r;
        mul_b     = MUL_BW'(w_r[WW-1:32]);
        state_nxt = ST_FLO;
      end

      ST_FLO: begin
        acc_g_nxt = cpg_neg_r ? (acc_g_r - term_ext) : (acc_g_r + term_ext);
        mul_a     = cpf_mag_r;
        mul_b     = w_r[31:0];
        state_nxt = ST_FHI;
      end

      ST_FHI: begin
        lo_nxt    = prod_r;
        mul_a     = cpf_mag_r;
        mul_b     = MUL_BW'(w_r[WW-1:32]);
        state_nxt = ST_FACC;
      end

      ST_FACC: begin
        acc_f_nxt = cpf_neg_r ? (acc_f_r - term_ext) : (acc_f_r + term_ext);
        if (l_r == l_last) begin
          state_nxt = ST_FIN;
        end else begin
          l_nxt = LW'(l_r + LW'(1));
          w_nxt = w_r + WW'({inv_beta_r, 1'b0});
          if (l_r == '0) begin
            // order one: P_1 = x
            p_nxt     = p1_r;
            state_nxt = ST_CPG;
          end else begin
            mul_a     = {1'b0, mag32(x_r)};
            mul_b     = mag32(p1_r);
            mul_neg   = x_r[31] ^ p1_r[31];
            state_nxt = ST_T1;
          end
        end
      end

      ST_T1: begin
        xp_mag_nxt = rnd_sum[61:30];
        xp_neg_nxt = prod_neg_r;
        recip_nxt  = recip_tab[l_r];
        mul_a      = {1'b0, mag32(p2_r)};
        mul_b      = 32'(l_r) - 32'd1;
        mul_neg    = p2_r[31];
        state_nxt  = ST_T2;
      end

      ST_T2: begin
        t2_nxt    = prod_sg;
        mul_a     = {1'b0, xp_mag_r};
        mul_b     = 32'({l_r, 1'b0}) - 32'd1;
        mul_neg   = xp_neg_r;
        state_nxt = ST_T3;
      end

      ST_T3: begin
        num_nxt   = prod_sg - t2_r;
        state_nxt = ST_NABS;
      end

      ST_NABS: begin
        num_mag_nxt = num_abs;
        num_neg_nxt = num_r[NMW];
        state_nxt   = ST_RLO;
      end

      ST_RLO: begin
        mul_a     = MUL_AW'(num_mag_r[31:0]);
        mul_b     = recip_r;
        state_nxt = ST_RHI;
      end

      ST_RHI: begin
        lo_nxt    = prod_r;
        mul_a     = MUL_AW'(num_mag_r[NMW-1:32]);
        mul_b     = recip_r;
        state_nxt = ST_RP;
      end

      ST_RP: begin
        p_nxt     = p_sat;
        p1_nxt    = p_sat;
        p2_nxt    = p1_r;
        state_nxt = ST_CPG;
      end

      ST_FIN: begin
        out_point_nxt = idx_r;
        out_g_nxt     = sat_acc(acc_g_r);
        out_f_nxt     = sat_acc(acc_f_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      l_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      l_r         <= l_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_coeffs_r <= NUM_COEFFS_RST;
      x_step_r     <= X_STEP_RST;
      inv_beta_r   <= INV_BETA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_COEFFS: num_coeffs_r <= cfg_data[6:0];
        CFG_X_STEP:     x_step_r     <= cfg_data[30:0];
        CFG_INV_BETA:   inv_beta_r   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers and the shared multiplier
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    x_r         <= x_nxt;
    p_r         <= p_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    w_r         <= w_nxt;
    acc_g_r     <= acc_g_nxt;
    acc_f_r     <= acc_f_nxt;
    cpg_mag_r   <= cpg_mag_nxt;
    cpg_neg_r   <= cpg_neg_nxt;
    cpf_mag_r   <= cpf_mag_nxt;
    cpf_neg_r   <= cpf_neg_nxt;
    lo_r        <= lo_nxt;
    xp_mag_r    <= xp_mag_nxt;
    xp_neg_r    <= xp_neg_nxt;
    t2_r        <= t2_nxt;
    num_r       <= num_nxt;
    num_mag_r   <= num_mag_nxt;
    num_neg_r   <= num_neg_nxt;
    recip_r     <= recip_nxt;
    out_point_r <= out_point_nxt;
    out_g_r     <= out_g_nxt;
    out_f_r     <= out_f_nxt;
    prod_r      <= PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_neg_r  <= mul_neg;
  end

  // coefficient stores, read at l_nxt so the registered read data follows the order counter
  always_ff @(posedge clk) begin
    if (mem_we) begin
      g_mem[in_index[LW-1:0]] <= in_g_coeff;
      f_mem[in_index[LW-1:0]] <= in_f_coeff;
    end
    g_rd_r <= g_mem[l_nxt];
    f_rd_r <= f_mem[l_nxt];
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_point_echo = out_point_r;
  assign out_g_value    = out_g_r;
  assign out_f_value    = out_f_r;

endmodule

@@ rtl/lse_checker.sv @@
`timescale 1ns / 1ps
// lse_checker.sv: port-level checks of the Legendre series evaluator, bound to the top.
// Depends on lse_pkg (command codes) and legendre_series_evaluation (bind target).
module lse_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input lse_pkg::cmd_t in_cmd,
  input logic          out_valid
);

  import lse_pkg::*;

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // an evaluate transaction occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_EVAL) |=> busy)
    else $error("busy not raised after evaluate");

  // a load transaction completes in its own cycle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> !busy)
    else $error("busy raised after load");

  // a result shows exactly when an evaluation finishes
  a_result_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result strobe without end of evaluation");

endmodule

bind legendre_series_evaluation lse_checker u_lse_checker (.*);
